@@ rtl/mspg_pkg.sv @@
// Shared types, constants and helpers for the multichannel step pulse generator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package mspg_pkg;

    // Channel and counter geometry
    localparam int CHANNELS  = 4;
    localparam int CMP_W     = 16;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LVL_W     = 4;

    // Field widths
    localparam int CMD_W     = 3;
    localparam int CH_W      = 2;
    localparam int SPEED_W   = 21;
    localparam int MAG_W     = 20;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int DELTA_W   = 32;
    localparam int INV_W     = 4;

    // Half interval math: TICK_RATE / (2 * |pps|)
    localparam int unsigned TICK_RATE = 1000000;
    localparam int          Q_W       = $clog2(TICK_RATE + 1);
    localparam int          DIV_W     = MAG_W + 1;
    localparam int unsigned HALF_MIN  = 8;
    localparam int unsigned HALF_TOP  = (CMP_W >= 16) ? 32'hFFFF : ((32'd1 << CMP_W) - 1);

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] MAX_SPEED_RST = CFG_W'(50000);
    localparam logic [CFG_W-1:0] MIN_SPEED_RST = CFG_W'(8);

    // Command codes, also used as the internal operation code
    typedef enum logic [CMD_W-1:0] {
        OP_TICK  = 3'd0,
        OP_SET   = 3'd1,
        OP_TAKE  = 3'd2,
        OP_ESTOP = 3'd3,
        OP_EN    = 3'd4,
        OP_DIS   = 3'd5,
        OP_NOP   = 3'd7
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SPEED = 2'd0,
        CFG_MIN_SPEED = 2'd1,
        CFG_INVERT    = 2'd2,
        CFG_EN_LOW    = 2'd3
    } t_cfg_idx;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_RESULT
    } t_state;

    // Classified item passed from front to back
    typedef struct packed {
        t_op                        op;
        logic [CH_IDX_W-1:0]        ch;
        logic signed [SPEED_W-1:0]  pps;
        logic [MAG_W-1:0]           mag;
    } t_item;

    // Configuration register group
    typedef struct packed {
        logic [CFG_W-1:0] max_speed;
        logic [CFG_W-1:0] min_speed;
        logic [INV_W-1:0] invert_mask;
        logic             en_low;
    } t_cfg;

    // Divider handshake
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
    } t_div_rsp;

    // Clamp a raw quotient into the legal half interval range
    function automatic logic [CMP_W-1:0] half_clamp(input logic [Q_W-1:0] q);
        if (q < Q_W'(HALF_MIN)) begin
            return CMP_W'(HALF_MIN);
        end else if (q > Q_W'(HALF_TOP)) begin
            return CMP_W'(HALF_TOP);
        end else begin
            return CMP_W'(q);
        end
    endfunction

endpackage

@@ rtl/mspg_if.sv @@
// Valid/ready channel interfaces for command items and result items.
// Depends on mspg_pkg for field widths.
`timescale 1ns / 1ps
interface mspg_in_if;
    import mspg_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic [CH_W-1:0]            channel;
    logic signed [SPEED_W-1:0]  speed_pps;

    modport source (output valid, output command, output channel, output speed_pps,
                    input ready);
    modport sink   (input valid, input command, input channel, input speed_pps,
                    output ready);
endinterface

interface mspg_out_if;
    import mspg_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [LVL_W-1:0]           pulse_levels;
    logic [LVL_W-1:0]           direction_levels;
    logic [LVL_W-1:0]           enable_levels;
    logic signed [DELTA_W-1:0]  step_delta;

    modport source (output valid, output pulse_levels, output direction_levels,
                    output enable_levels, output step_delta, input ready);
    modport sink   (input valid, input pulse_levels, input direction_levels,
                    input enable_levels, input step_delta, output ready);
endinterface

@@ rtl/mspg_front.sv @@
// Front end: accepts command items, decodes the command and clamps the speed request.
// Depends on mspg_pkg and mspg_in_if.
`timescale 1ns / 1ps
module mspg_front (
    mspg_in_if.sink                       i_in,
    input  logic [mspg_pkg::CFG_W-1:0]    i_max_speed,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output mspg_pkg::t_item               o_q_item
);
    import mspg_pkg::*;

    logic signed [SPEED_W:0] w_pps;
    logic signed [SPEED_W:0] w_lim;
    logic signed [SPEED_W:0] w_clamped;
    logic                    w_ok;
    t_op                     w_op;

    // Take an item whenever the queue has room
    assign i_in.ready = !i_q_full;
    assign o_q_push   = i_in.valid && !i_q_full;

    // Decode the command; drop channel commands aimed past the last channel
    always_comb begin
        w_ok = 32'(i_in.channel) < CHANNELS;
        unique case (t_op'(i_in.command))
            OP_TICK:  w_op = OP_TICK;
            OP_SET:   w_op = w_ok ? OP_SET  : OP_NOP;
            OP_TAKE:  w_op = w_ok ? OP_TAKE : OP_NOP;
            OP_ESTOP: w_op = OP_ESTOP;
            OP_EN:    w_op = w_ok ? OP_EN   : OP_NOP;
            OP_DIS:   w_op = w_ok ? OP_DIS  : OP_NOP;
            default:  w_op = OP_NOP;
        endcase
    end

    // Clamp the signed request to plus or minus the speed limit
    always_comb begin
        w_pps = (SPEED_W + 1)'(i_in.speed_pps);
        w_lim = $signed({2'b00, i_max_speed});
        if (w_pps > w_lim) begin
            w_clamped = w_lim;
        end else if (w_pps < -w_lim) begin
            w_clamped = -w_lim;
        end else begin
            w_clamped = w_pps;
        end
    end

    always_comb begin
        o_q_item.op  = w_op;
        o_q_item.ch  = CH_IDX_W'(i_in.channel);
        o_q_item.pps = w_clamped[SPEED_W-1:0];
        o_q_item.mag = w_clamped[SPEED_W] ? MAG_W'(-w_clamped) : MAG_W'(w_clamped);
    end

endmodule

@@ rtl/mspg_queue.sv @@
// Two-entry queue of decoded items between the front end and the back end.
// Depends on mspg_pkg.
`timescale 1ns / 1ps
module mspg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mspg_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output mspg_pkg::t_item o_item
);
    import mspg_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ rtl/mspg_div.sv @@
// Radix-2 restoring divider: computes TICK_RATE / divisor, one quotient bit a cycle.
// Depends on mspg_pkg.
`timescale 1ns / 1ps
module mspg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mspg_pkg::t_div_req i_req,
    output mspg_pkg::t_div_rsp o_rsp
);
    import mspg_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W:0]   r_rem;
    logic [Q_W-1:0]   r_quo;
    logic [Q_W-1:0]   r_dvd;
    logic [DIV_W-1:0] r_dsr;

    logic [DIV_W:0]   w_trial;
    logic             w_ge;
    logic [DIV_W:0]   n_rem;
    logic             w_last;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem[DIV_W-1:0], r_dvd[Q_W-1]};
        w_ge    = w_trial >= {1'b0, r_dsr};
        n_rem   = w_ge ? (w_trial - {1'b0, r_dsr}) : w_trial;
        w_last  = r_cnt == CNT_W'(Q_W - 1);
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= '0;
            r_dvd <= Q_W'(TICK_RATE);
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[Q_W-2:0], w_ge};
            r_dvd <= {r_dvd[Q_W-2:0], 1'b0};
        end
    end

endmodule

@@ rtl/mspg_back.sv @@
// Back end: executes queued items on the channel state and registers each result.
// Depends on mspg_pkg, mspg_out_if and the divider in mspg_div.
`timescale 1ns / 1ps
module mspg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mspg_pkg::t_cfg     i_cfg,
    input  logic               i_q_valid,
    input  mspg_pkg::t_item    i_q_item,
    output logic               o_q_pop,
    output mspg_pkg::t_div_req o_div_req,
    input  mspg_pkg::t_div_rsp i_div_rsp,
    mspg_out_if.source         o_out
);
    import mspg_pkg::*;

    t_state r_state;
    t_state n_state;
    t_item  r_item;

    // Channel state
    logic [CMP_W-1:0]          r_counter;
    logic [CMP_W-1:0]          r_cmp     [CHANNELS];
    logic [CMP_W-1:0]          r_half    [CHANNELS];
    logic [CHANNELS-1:0]       r_phase;
    logic [CHANNELS-1:0]       r_running;
    logic signed [1:0]         r_step_dir [CHANNELS];
    logic [DELTA_W-1:0]        r_total   [CHANNELS];
    logic [DELTA_W-1:0]        r_taken   [CHANNELS];
    logic signed [SPEED_W-1:0] r_cached  [CHANNELS];
    logic [CHANNELS-1:0]       r_cache_valid;
    logic [CHANNELS-1:0]       r_dir_pin;
    logic [CHANNELS-1:0]       r_en_pin;
    logic [DELTA_W-1:0]        r_delta;

    // Result register
    logic                      r_out_valid;
    logic [LVL_W-1:0]          r_out_pulse;
    logic [LVL_W-1:0]          r_out_dir;
    logic [LVL_W-1:0]          r_out_en;
    logic [DELTA_W-1:0]        r_out_delta;

    logic                w_exec;
    logic                w_load_out;
    logic                w_same;
    logic                w_below;
    logic                w_zero;
    logic                w_need_div;
    logic                w_apply;
    logic [CMP_W-1:0]    w_half;
    logic [CMP_W-1:0]    n_counter;
    logic [CHANNELS-1:0] w_hit;
    logic [LVL_W-1:0]    w_pl;
    logic [LVL_W-1:0]    w_dl;
    logic [LVL_W-1:0]    w_el;

    // Classify the held set-speed request
    always_comb begin
        w_same     = r_cache_valid[r_item.ch] && (r_cached[r_item.ch] == r_item.pps);
        w_below    = 32'(r_item.mag) < 32'(i_cfg.min_speed);
        w_zero     = r_item.mag == '0;
        w_need_div = (r_item.op == OP_SET) && !w_same && !w_below && !w_zero;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = w_need_div ? S_DIV : S_RESULT;
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_q_pop           = (r_state == S_IDLE) && i_q_valid && !r_out_valid;
        w_exec            = r_state == S_EXEC;
        w_load_out        = r_state == S_RESULT;
        o_div_req.start   = w_exec && w_need_div;
        o_div_req.divisor = {r_item.mag, 1'b0};
        w_apply           = (w_exec && (r_item.op == OP_SET) && !w_same && !w_below && w_zero)
                          || ((r_state == S_DIV) && i_div_rsp.done);
        w_half            = (r_state == S_DIV) ? half_clamp(i_div_rsp.quotient)
                                               : CMP_W'(HALF_TOP);
    end

    // Compare match for the advanced counter
    always_comb begin
        n_counter = r_counter + 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
            w_hit[c] = r_running[c] && (r_cmp[c] == n_counter);
        end
    end

    // Pack pin levels for the result
    always_comb begin
        w_pl = '0;
        w_dl = '0;
        w_el = '0;
        for (int c = 0; c < LVL_W; c++) begin
            if (c < CHANNELS) begin
                w_pl[c] = r_phase[c];
                w_dl[c] = r_dir_pin[c];
                w_el[c] = r_en_pin[c];
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.pulse_levels     = r_out_pulse;
    assign o_out.direction_levels = r_out_dir;
    assign o_out.enable_levels    = r_out_en;
    assign o_out.step_delta       = r_out_delta;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_counter     <= '0;
            r_phase       <= '0;
            r_running     <= '0;
            r_cache_valid <= '0;
            r_dir_pin     <= '0;
            r_en_pin      <= '0;
            r_out_valid   <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_step_dir[c] <= 2'sd1;
                r_total[c]    <= '0;
                r_taken[c]    <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_exec) begin
                unique case (r_item.op)
                    OP_TICK: begin
                        r_counter <= n_counter;
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (w_hit[c]) begin
                                r_phase[c] <= !r_phase[c];
                                if (!r_phase[c]) begin
                                    r_total[c] <= r_total[c]
                                                + {{(DELTA_W-2){r_step_dir[c][1]}}, r_step_dir[c]};
                                end
                            end
                        end
                    end
                    OP_SET: begin
                        if (!w_same) begin
                            r_cache_valid[r_item.ch] <= 1'b1;
                            r_dir_pin[r_item.ch]     <= !r_item.pps[SPEED_W-1]
                                                      ^ i_cfg.invert_mask[r_item.ch];
                            r_step_dir[r_item.ch]    <= r_item.pps[SPEED_W-1] ? -2'sd1 : 2'sd1;
                            if (w_below) begin
                                r_running[r_item.ch] <= 1'b0;
                                r_phase[r_item.ch]   <= 1'b0;
                            end
                        end
                    end
                    OP_TAKE: begin
                        r_taken[r_item.ch] <= r_total[r_item.ch];
                    end
                    OP_ESTOP: begin
                        r_running     <= '0;
                        r_phase       <= '0;
                        r_cache_valid <= '0;
                        r_en_pin      <= {CHANNELS{i_cfg.en_low}};
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_step_dir[c] <= 2'sd0;
                        end
                    end
                    OP_EN: begin
                        r_en_pin[r_item.ch] <= !i_cfg.en_low;
                    end
                    OP_DIS: begin
                        r_en_pin[r_item.ch] <= i_cfg.en_low;
                    end
                    OP_NOP: begin
                    end
                    default: begin
                    end
                endcase
            end
            // Start a stopped channel once its half interval is known
            if (w_apply && !r_running[r_item.ch]) begin
                r_running[r_item.ch] <= 1'b1;
                r_phase[r_item.ch]   <= 1'b0;
            end
            // Hold the result until the sink takes it
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (w_exec) begin
            r_delta <= (r_item.op == OP_TAKE) ? (r_total[r_item.ch] - r_taken[r_item.ch])
                                              : '0;
            if (r_item.op == OP_TICK) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (w_hit[c]) begin
                        r_cmp[c] <= r_cmp[c] + r_half[c];
                    end
                end
            end
            if ((r_item.op == OP_SET) && !w_same) begin
                r_cached[r_item.ch] <= r_item.pps;
            end
        end
        if (w_apply) begin
            r_half[r_item.ch] <= w_half;
            if (!r_running[r_item.ch]) begin
                r_cmp[r_item.ch] <= r_counter + w_half;
            end
        end
        if (w_load_out) begin
            r_out_pulse <= w_pl;
            r_out_dir   <= w_dl;
            r_out_en    <= w_el;
            r_out_delta <= r_delta;
        end
    end

endmodule

@@ rtl/multichannel_step_pulse_generator.sv @@
// An item goes from the queue through fetch, execute and result into the result register
//   when the back end is free; set speed that needs a new half interval also waits on the
//   one-bit-per-cycle divider. The next item is fetched only after the sink takes the
//   waiting result; the front end keeps accepting into a two-entry queue while a result
//   waits.
// Reset (synchronous, active low): channels stopped, pins low, step direction +1, counts zero,
//   queue empty, configuration back to its defaults.
`timescale 1ns / 1ps
module multichannel_step_pulse_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mspg_in_if.sink                           i_in,
    mspg_out_if.source                        o_out,
    input  logic                              i_cfg_wr_en,
    input  logic [mspg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mspg_pkg::CFG_W-1:0]        i_cfg_data
);
    import mspg_pkg::*;

    t_cfg     r_cfg;
    logic     w_q_push;
    t_item    w_push_item;
    logic     w_q_full;
    logic     w_q_valid;
    t_item    w_head_item;
    logic     w_q_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed   <= MAX_SPEED_RST;
            r_cfg.min_speed   <= MIN_SPEED_RST;
            r_cfg.invert_mask <= '0;
            r_cfg.en_low      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_SPEED: r_cfg.max_speed   <= i_cfg_data;
                CFG_MIN_SPEED: r_cfg.min_speed   <= i_cfg_data;
                CFG_INVERT:    r_cfg.invert_mask <= i_cfg_data[INV_W-1:0];
                CFG_EN_LOW:    r_cfg.en_low      <= i_cfg_data[0];
                default:       r_cfg.en_low      <= r_cfg.en_low;
            endcase
        end
    end

    mspg_front u_front (
        .i_in        (i_in),
        .i_max_speed (r_cfg.max_speed),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_item    (w_push_item)
    );

    mspg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_push_item),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_head_item)
    );

    mspg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    mspg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_head_item),
        .o_q_pop   (w_q_pop),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp),
        .o_out     (o_out)
    );

endmodule

@@ rtl/mspg_checker.sv @@
// Port-level checks for the multichannel step pulse generator, bound to the top level.
// Depends on mspg_pkg for widths.
`timescale 1ns / 1ps
module mspg_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [mspg_pkg::LVL_W-1:0]       i_out_pulse,
    input logic [mspg_pkg::LVL_W-1:0]       i_out_dir,
    input logic [mspg_pkg::LVL_W-1:0]       i_out_en,
    input logic [mspg_pkg::DELTA_W-1:0]     i_out_delta
);
    import mspg_pkg::*;

    // Reset empties the result register
    a_rst_out_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Reset empties the queue, so items are taken right away
    a_rst_in_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // Results never come back to back: valid drops after each transfer
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid)
        else $error("back-to-back results");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_pulse) && $stable(i_out_dir)
            && $stable(i_out_en) && $stable(i_out_delta))
        else $error("result payload changed while stalled");

endmodule

bind multichannel_step_pulse_generator mspg_checker u_mspg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pulse (o_out.pulse_levels),
    .i_out_dir   (o_out.direction_levels),
    .i_out_en    (o_out.enable_levels),
    .i_out_delta (o_out.step_delta)
);

@@ test/mspg_checker.sv @@
// Scoreboard for the multichannel step pulse generator: watches the command, result and
// register-write ports, keeps its own copy of the channel state and checks every result.
// Depends on mspg_pkg and the channel interfaces in mspg_if.
`timescale 1ns / 1ps
module mspg_scoreboard (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mspg_in_if                             i_cmd_mon,
    mspg_out_if                            i_lvl_mon,
    input  logic                           i_cfg_wr_en,
    input  logic [mspg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mspg_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import mspg_pkg::*;

    typedef struct packed {
        logic [LVL_W-1:0]   pulse;
        logic [LVL_W-1:0]   dir;
        logic [LVL_W-1:0]   en;
        logic [DELTA_W-1:0] delta;
    } t_pin_levels;

    // Register copies
    logic [CFG_W-1:0] max_speed;
    logic [CFG_W-1:0] min_speed;
    logic [INV_W-1:0] inv_mask;
    logic             en_low;

    // Channel state
    logic [CMP_W-1:0]          tick_count;
    logic [CMP_W-1:0]          next_edge    [CHANNELS];
    logic [CMP_W-1:0]          half_period  [CHANNELS];
    logic                      pulse_q      [CHANNELS];
    logic                      active       [CHANNELS];
    logic signed [1:0]         step_sign    [CHANNELS];
    logic [DELTA_W-1:0]        step_tally   [CHANNELS];
    logic [DELTA_W-1:0]        taken_count  [CHANNELS];
    logic signed [SPEED_W-1:0] last_request [CHANNELS];
    logic                      request_held [CHANNELS];
    logic                      dir_pin      [CHANNELS];
    logic                      en_pin       [CHANNELS];

    t_pin_levels pin_levels_due[$];
    int          fails;

    // Return the model to its power-up state
    function automatic void clear_channels();
        max_speed  = MAX_SPEED_RST;
        min_speed  = MIN_SPEED_RST;
        inv_mask   = '0;
        en_low     = 1'b0;
        tick_count = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            next_edge[c]    = '0;
            half_period[c]  = '0;
            pulse_q[c]      = 1'b0;
            active[c]       = 1'b0;
            step_sign[c]    = 2'sd1;
            step_tally[c]   = '0;
            taken_count[c]  = '0;
            last_request[c] = '0;
            request_held[c] = 1'b0;
            dir_pin[c]      = 1'b0;
            en_pin[c]       = 1'b0;
        end
    endfunction

    // Clamp, filter repeats, drive direction, then stop or retime the channel
    function automatic void apply_speed(int c, logic signed [SPEED_W-1:0] raw);
        int          pps;
        int          lim;
        int unsigned mag;
        int unsigned q;
        pps = raw;
        lim = int'(max_speed);
        if (pps > lim) pps = lim;
        if (pps < -lim) pps = -lim;
        if (request_held[c] && int'(last_request[c]) == pps) return;
        last_request[c] = SPEED_W'(pps);
        request_held[c] = 1'b1;
        dir_pin[c]   = (pps >= 0) ^ inv_mask[c];
        step_sign[c] = (pps >= 0) ? 2'sd1 : -2'sd1;
        mag = (pps >= 0) ? pps : -pps;
        if (mag < min_speed) begin
            active[c]  = 1'b0;
            pulse_q[c] = 1'b0;
            return;
        end
        if (mag == 0) begin
            q = HALF_TOP;
        end else begin
            q = TICK_RATE / (2 * mag);
            if (q < HALF_MIN) q = HALF_MIN;
            if (q > HALF_TOP) q = HALF_TOP;
        end
        half_period[c] = CMP_W'(q);
        if (!active[c]) begin
            next_edge[c] = tick_count + CMP_W'(q);
            pulse_q[c]   = 1'b0;
            active[c]    = 1'b1;
        end
    endfunction

    // Advance the counter and toggle every channel whose compare point is hit
    function automatic void advance_tick();
        int d;
        tick_count = tick_count + 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
            if (active[c] && next_edge[c] == tick_count) begin
                if (!pulse_q[c]) begin
                    d             = step_sign[c];
                    pulse_q[c]    = 1'b1;
                    step_tally[c] = step_tally[c] + DELTA_W'(d);
                end else begin
                    pulse_q[c] = 1'b0;
                end
                next_edge[c] = next_edge[c] + half_period[c];
            end
        end
    endfunction

    // Execute one command and snapshot the pins after it
    function automatic t_pin_levels run_command(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                                                logic signed [SPEED_W-1:0] pps);
        t_pin_levels lv;
        lv = '0;
        case (cmd)
            OP_TICK: advance_tick();
            OP_SET:  apply_speed(ch, pps);
            OP_TAKE: begin
                lv.delta        = step_tally[ch] - taken_count[ch];
                taken_count[ch] = step_tally[ch];
            end
            OP_ESTOP: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    active[c]       = 1'b0;
                    pulse_q[c]      = 1'b0;
                    step_sign[c]    = 2'sd0;
                    request_held[c] = 1'b0;
                    en_pin[c]       = en_low;
                end
            end
            OP_EN:   en_pin[ch] = !en_low;
            OP_DIS:  en_pin[ch] = en_low;
            default: ;
        endcase
        for (int c = 0; c < CHANNELS; c++) begin
            lv.pulse[c] = pulse_q[c];
            lv.dir[c]   = dir_pin[c];
            lv.en[c]    = en_pin[c];
        end
        return lv;
    endfunction

    // Retire results against the oldest prediction, then predict new transfers
    always @(posedge i_clk) begin
        t_pin_levels want;
        t_pin_levels got;
        if (!i_rst_n) begin
            clear_channels();
            pin_levels_due.delete();
            fails = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MAX_SPEED: max_speed = i_cfg_data;
                    CFG_MIN_SPEED: min_speed = i_cfg_data;
                    CFG_INVERT:    inv_mask  = i_cfg_data[INV_W-1:0];
                    CFG_EN_LOW:    en_low    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_lvl_mon.valid && i_lvl_mon.ready) begin
                got.pulse = i_lvl_mon.pulse_levels;
                got.dir   = i_lvl_mon.direction_levels;
                got.en    = i_lvl_mon.enable_levels;
                got.delta = i_lvl_mon.step_delta;
                if (pin_levels_due.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fails++;
                end else begin
                    want = pin_levels_due.pop_front();
                    if (got.pulse !== want.pulse) begin
                        $error("pulse_levels: expected %h, actual %h", want.pulse, got.pulse);
                        fails++;
                    end
                    if (got.dir !== want.dir) begin
                        $error("direction_levels: expected %h, actual %h", want.dir, got.dir);
                        fails++;
                    end
                    if (got.en !== want.en) begin
                        $error("enable_levels: expected %h, actual %h", want.en, got.en);
                        fails++;
                    end
                    if (got.delta !== want.delta) begin
                        $error("step_delta: expected %0d, actual %0d",
                               $signed(want.delta), $signed(got.delta));
                        fails++;
                    end
                end
            end
            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                pin_levels_due.push_back(run_command(i_cmd_mon.command, i_cmd_mon.channel,
                                                     i_cmd_mon.speed_pps));
            end
        end
        o_pending    <= pin_levels_due.size();
        o_fail_count <= fails;
    end

endmodule

@@ test/multichannel_step_pulse_generator_tb.sv @@
// Stimulus and verdict for the multichannel step pulse generator: directed commands,
// a stall-free tick burst and random phases under several register settings.
// Depends on mspg_pkg, mspg_if, the generator RTL and the scoreboard in mspg_checker.sv.
`timescale 1ns / 1ps
module multichannel_step_pulse_generator_tb;
    import mspg_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE   = 3'd6;
    localparam int               CYCLE_LIMIT = 2000000;
    localparam int               BURST_TICKS = 40;
    localparam int               PHASE_ITEMS = 180;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic idling;
    int   pending;
    int   fail_count;
    logic signed [SPEED_W-1:0] last_req [CHANNELS];

    mspg_in_if  cmd_ch ();
    mspg_out_if lvl_ch ();

    multichannel_step_pulse_generator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (cmd_ch),
        .o_out       (lvl_ch),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mspg_scoreboard checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd_mon    (cmd_ch),
        .i_lvl_mon    (lvl_ch),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 clk = ~clk;

    // Stall the result side at random while idling is set
    always @(posedge clk) begin
        lvl_ch.ready <= !(idling && $urandom_range(99) < 37);
    end

    // Present one command and hold it until its transfer
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                            input logic signed [SPEED_W-1:0] pps);
        while (idling && $urandom_range(99) < 37) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= cmd;
        cmd_ch.channel   <= ch;
        cmd_ch.speed_pps <= pps;
        do @(posedge clk); while (!cmd_ch.ready);
    endtask

    // Hold off the command side until every result is back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Write all four registers; only called while the block is idle
    task automatic program_cfg(input int max_spd, input int min_spd, input int inv,
                               input int en_lo);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MAX_SPEED;
        cfg_data  <= CFG_W'(max_spd);
        @(posedge clk);
        cfg_index <= CFG_MIN_SPEED;
        cfg_data  <= CFG_W'(min_spd);
        @(posedge clk);
        cfg_index <= CFG_INVERT;
        cfg_data  <= CFG_W'(inv);
        @(posedge clk);
        cfg_index <= CFG_EN_LOW;
        cfg_data  <= CFG_W'(en_lo);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int r;
        int k;
        int mag;
        logic [CH_W-1:0] ch;
        logic signed [SPEED_W-1:0] spd;

        idling = 1'b1;
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= CFG_MAX_SPEED;
        cfg_data         <= '0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.command   <= OP_TICK;
        cmd_ch.channel   <= '0;
        cmd_ch.speed_pps <= '0;
        for (int c = 0; c < CHANNELS; c++) last_req[c] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, clamping, stop below minimum, repeat filtering,
        // retime while running, unused codes, emergency stop
        send_cmd(OP_EN, 2'd0, '0);
        send_cmd(OP_EN, 2'd1, '0);
        send_cmd(OP_DIS, 2'd1, '0);
        send_cmd(OP_SET, 2'd0, 21'sd50000);
        send_cmd(OP_SET, 2'd1, -21'sd1000000);
        send_cmd(OP_SET, 2'd2, 21'sd3);
        send_cmd(OP_SET, 2'd3, 21'sd1000);
        send_cmd(OP_SET, 2'd0, 21'sd50000);
        repeat (10) send_cmd(OP_TICK, 2'd0, '0);
        send_cmd(OP_SET, 2'd0, 21'sd20000);
        send_cmd(OP_TAKE, 2'd0, '0);
        send_cmd(OP_TAKE, 2'd1, '0);
        send_cmd(CMD_SPARE, 2'd3, 21'sd1000000);
        send_cmd(OP_NOP, 2'd2, -21'sd1);
        send_cmd(OP_ESTOP, 2'd0, '0);
        send_cmd(OP_TAKE, 2'd1, '0);
        drain();

        // Extremes: full speed, zero speed with no minimum, inverted pins, active-low enables
        program_cfg(1000000, 0, 15, 1);
        send_cmd(OP_SET, 2'd0, 21'sd1000000);
        send_cmd(OP_SET, 2'd1, -21'sd1000000);
        send_cmd(OP_SET, 2'd2, 21'sd0);
        send_cmd(OP_SET, 2'd3, -21'sd1);
        send_cmd(OP_EN, 2'd2, '0);
        send_cmd(OP_DIS, 2'd3, '0);

        // Run a tick burst with no stalls on either side
        idling = 1'b0;
        repeat (BURST_TICKS) send_cmd(OP_TICK, 2'($urandom_range(3)), '0);
        for (int c = 0; c < CHANNELS; c++) send_cmd(OP_TAKE, CH_W'(c), '0);
        idling = 1'b1;
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: program_cfg(1000000, 0, 5, 0);
                1: program_cfg(1, 1000000, 10, 1);
                2: program_cfg(50000, 8, 0, 0);
                default: program_cfg($urandom_range(1000000, 1), $urandom_range(2000),
                                     $urandom_range(15), $urandom_range(1));
            endcase
            idling = (p != 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                r   = $urandom_range(99);
                ch  = CH_W'($urandom_range(3));
                spd = SPEED_W'(int'($urandom_range(2000000)) - 1000000);
                if (r < 55) begin
                    send_cmd(OP_TICK, ch, spd);
                end else if (r < 72) begin
                    // Mostly fast requests so pulses come within a few ticks
                    k = $urandom_range(9);
                    if (k == 0) begin
                        spd = last_req[ch];
                    end else begin
                        if (k <= 4) mag = $urandom_range(1000000, 20000);
                        else if (k <= 6) mag = $urandom_range(20000, 100);
                        else if (k == 7) mag = $urandom_range(16);
                        else mag = $urandom_range(1000000);
                        spd = SPEED_W'($urandom_range(1) ? -mag : mag);
                        last_req[ch] = spd;
                    end
                    send_cmd(OP_SET, ch, spd);
                end else if (r < 82) begin
                    send_cmd(OP_TAKE, ch, spd);
                end else if (r < 88) begin
                    send_cmd(OP_EN, ch, spd);
                end else if (r < 94) begin
                    send_cmd(OP_DIS, ch, spd);
                end else if (r < 96) begin
                    send_cmd(OP_ESTOP, ch, spd);
                end else if (r < 98) begin
                    send_cmd($urandom_range(1) ? CMD_SPARE : OP_NOP, ch, spd);
                end else begin
                    drain();
                end
            end
            drain();
        end

        // Let any stray result surface before the verdict
        repeat (30) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/mspg_pkg.sv
rtl/mspg_if.sv
rtl/mspg_front.sv
rtl/mspg_queue.sv
rtl/mspg_div.sv
rtl/mspg_back.sv
rtl/multichannel_step_pulse_generator.sv
rtl/mspg_checker.sv
test/mspg_checker.sv
test/multichannel_step_pulse_generator_tb.sv
